### hw/rtl/rcpc_pkg.sv
// shared types and constants for the ray convex polyhedron clip core
`timescale 1ns / 1ps
package rcpc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DOT_W     = 50;   // signed dot product minus offset
    localparam int MAG_W     = 49;   // magnitude of a dot term
    localparam int QUO_W     = 33;   // quotient before clamping
    localparam int REM_W     = MAG_W + FRAC_BITS;
    localparam int DSH_W     = MAG_W + QUO_W;
    localparam int BIT_W     = 6;    // quotient bit index, 0 to QUO_W-1

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_RAY  = 1'b1;

    localparam logic [1:0] CFG_PLANE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PARALLEL_SLOP = 2'd1;
    localparam logic [1:0] CFG_SLANT_EPSILON = 2'd2;

    typedef struct packed {
        logic               func;
        logic [5:0]         plane_index;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] entry_dist;
        logic signed [31:0] exit_dist;
        logic [5:0]         entry_face;
        logic [5:0]         exit_face;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_DROP = 2'd1,
        CMD_RAY  = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd     cmd;
        t_in_item item;
    } t_job;

    typedef struct packed {
        logic [6:0]  plane_count;
        logic [15:0] parallel_slop;
        logic [15:0] slant_epsilon;
    } t_cfg;

endpackage

### hw/rtl/rcpc_front.sv
// front end: input queue that decodes each item into a job
`timescale 1ns / 1ps
module rcpc_front #(
    parameter int MAX_PLANES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  rcpc_pkg::t_in_item i_item,
    input  logic              i_take,
    output logic              o_avail,
    output rcpc_pkg::t_job    o_job
);

    rcpc_pkg::t_job r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    rcpc_pkg::t_job w_job;
    logic           w_wr;
    logic           w_rd;

    always_comb begin
        w_job.item = i_item;
        if (i_item.func == rcpc_pkg::FUNC_RAY) begin
            w_job.cmd = rcpc_pkg::CMD_RAY;
        end else if (32'(i_item.plane_index) < MAX_PLANES) begin
            w_job.cmd = rcpc_pkg::CMD_LOAD;
        end else begin
            w_job.cmd = rcpc_pkg::CMD_DROP;
        end
    end

    assign full    = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_job   = r_q[r_rp];
    assign w_wr    = push && !full;
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

### hw/rtl/rcpc_resq.sv
// two-entry result queue in front of the output port
`timescale 1ns / 1ps
module rcpc_resq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rcpc_pkg::t_out_item i_item,
    output logic                o_full,
    input  logic                pop,
    output logic                empty,
    output rcpc_pkg::t_out_item o_item
);

    rcpc_pkg::t_out_item r_q [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                w_wr;
    logic                w_rd;

    assign o_full = (r_cnt == 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign o_item = r_q[r_rp];
    assign w_wr   = i_push && !o_full;
    assign w_rd   = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

### hw/rtl/rcpc_back.sv
// back end: plane table and the per-plane dot, divide and clip walk
`timescale 1ns / 1ps
module rcpc_back #(
    parameter int MAX_PLANES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_avail,
    input  rcpc_pkg::t_job      i_job,
    output logic                o_take,
    input  rcpc_pkg::t_cfg      i_cfg,
    input  logic                i_res_full,
    output logic                o_res_push,
    output rcpc_pkg::t_out_item o_res
);

    localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = $clog2(MAX_PLANES + 1) > 7 ? $clog2(MAX_PLANES + 1) : 7;
    localparam int DW = rcpc_pkg::DOT_W;
    localparam int MW = rcpc_pkg::MAG_W;
    localparam int FB = rcpc_pkg::FRAC_BITS;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_RD   = 10'b0000000010,
        S_MULO = 10'b0000000100,
        S_MULD = 10'b0000001000,
        S_SUM  = 10'b0000010000,
        S_CLS  = 10'b0000100000,
        S_OVF  = 10'b0001000000,
        S_DIV  = 10'b0010000000,
        S_UPD  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [127:0]       r_mem [MAX_PLANES];
    logic [127:0]       r_rd;
    logic [AW-1:0]      r_k;
    logic signed [31:0] r_ox, r_oy, r_oz, r_dx, r_dy, r_dz;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic signed [DW-1:0] r_dist, r_slant;
    logic [MW-1:0]      r_nmag, r_dmag;
    logic               r_neg, r_is_exit, r_is_entry, r_miss;
    logic [rcpc_pkg::REM_W-1:0] r_rem;
    logic [rcpc_pkg::QUO_W-1:0] r_q;
    logic [rcpc_pkg::BIT_W-1:0] r_bit;
    logic signed [31:0] r_in_d, r_out_d;
    logic [AW-1:0]      r_in_f, r_out_f;
    logic               r_in_v, r_out_v;
    rcpc_pkg::t_out_item r_res;

    logic signed [31:0] w_nx, w_ny, w_nz, w_off;
    logic signed [31:0] w_a0, w_a1, w_a2;
    logic signed [DW-1:0] w_sum, w_eps, w_slop;
    logic [CW-1:0]      w_n;
    logic [MW+FB:0]     w_thr;
    logic [rcpc_pkg::DSH_W-1:0] w_dsh;
    logic               w_ge;
    logic [rcpc_pkg::QUO_W-1:0] w_lim, w_qc, w_qs;
    logic signed [31:0] w_s;
    logic signed [31:0] u_in_d, u_out_d;
    logic [AW-1:0]      u_in_f, u_out_f;
    logic               u_in_v, u_out_v, u_miss, u_hit, u_done;

    assign {w_nx, w_ny, w_nz, w_off} = r_rd;
    assign o_take     = (r_state == S_IDLE) && i_avail;
    assign o_res_push = (r_state == S_OUT) && !i_res_full;
    assign o_res      = r_res;

    // operands of the shared multipliers: origin first, direction second
    assign w_a0 = (r_state == S_MULO) ? r_ox : r_dx;
    assign w_a1 = (r_state == S_MULO) ? r_oy : r_dy;
    assign w_a2 = (r_state == S_MULO) ? r_oz : r_dz;

    // floor shift of each exact product, then an exact sum
    assign w_sum = DW'(r_p0 >>> FB) + DW'(r_p1 >>> FB) + DW'(r_p2 >>> FB);
    assign w_eps  = $signed({{(DW-16){1'b0}}, i_cfg.slant_epsilon});
    assign w_slop = $signed({{(DW-16){1'b0}}, i_cfg.parallel_slop});
    assign w_n = (32'(i_cfg.plane_count) > MAX_PLANES) ? CW'(MAX_PLANES)
                                                         : CW'(i_cfg.plane_count);

    // integer part too large: n >= (lim >> FB + 1) * d
    assign w_thr = {2'b0, r_dmag, 15'b0} + (r_neg ? (MW+FB+1)'(r_dmag) : '0);
    assign w_dsh = rcpc_pkg::DSH_W'(r_dmag) << r_bit;
    assign w_ge  = rcpc_pkg::DSH_W'(r_rem) >= w_dsh;

    always_comb begin
        w_lim = r_neg ? 33'h080000000 : 33'h07FFFFFFF;
        w_qc  = (r_q > w_lim) ? w_lim : r_q;
        w_qs  = r_neg ? -w_qc : w_qc;
        w_s   = $signed(w_qs[31:0]);
        u_in_d  = r_in_d;
        u_in_f  = r_in_f;
        u_in_v  = r_in_v;
        u_out_d = r_out_d;
        u_out_f = r_out_f;
        u_out_v = r_out_v;
        if (r_is_exit) begin
            if (!r_out_v || w_s < r_out_d) begin
                u_out_d = w_s;
                u_out_f = r_k;
                u_out_v = 1'b1;
            end
        end else if (r_is_entry) begin
            if (!r_in_v || w_s > r_in_d) begin
                u_in_d = w_s;
                u_in_f = r_k;
                u_in_v = 1'b1;
            end
        end
        u_miss = r_miss || (u_in_v && u_out_v && u_in_d > u_out_d);
        u_hit  = !u_miss && u_in_v && u_out_v && u_in_d < u_out_d;
        u_done = u_miss || (r_k == '0);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_avail && i_job.cmd == rcpc_pkg::CMD_RAY) begin
                    n_state = (w_n == '0) ? S_OUT : S_RD;
                end
            end
            S_RD:   n_state = S_MULO;
            S_MULO: n_state = S_MULD;
            S_MULD: n_state = S_SUM;
            S_SUM:  n_state = S_CLS;
            S_CLS: begin
                if (r_slant < -w_eps || r_slant > w_eps) n_state = S_OVF;
                else                                     n_state = S_UPD;
            end
            S_OVF:  n_state = ({{(FB+1){1'b0}}, r_nmag} >= w_thr) ? S_UPD : S_DIV;
            S_DIV:  n_state = (r_bit == '0) ? S_UPD : S_DIV;
            S_UPD:  n_state = u_done ? S_OUT : S_RD;
            S_OUT:  n_state = i_res_full ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // plane table, one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (o_take && i_job.cmd == rcpc_pkg::CMD_LOAD) begin
            r_mem[AW'(i_job.item.plane_index)] <= {i_job.item.normal_x, i_job.item.normal_y,
                                                  i_job.item.normal_z, i_job.item.plane_offset};
        end
        r_rd <= r_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (o_take && i_job.cmd == rcpc_pkg::CMD_RAY) begin
                    r_ox    <= i_job.item.origin_x;
                    r_oy    <= i_job.item.origin_y;
                    r_oz    <= i_job.item.origin_z;
                    r_dx    <= i_job.item.dir_x;
                    r_dy    <= i_job.item.dir_y;
                    r_dz    <= i_job.item.dir_z;
                    r_k     <= AW'(w_n - CW'(1));
                    r_in_v  <= 1'b0;
                    r_out_v <= 1'b0;
                    r_in_d  <= '0;
                    r_out_d <= '0;
                    r_in_f  <= '0;
                    r_out_f <= '0;
                    r_miss  <= 1'b0;
                    r_res   <= '0;
                end
            end
            S_MULO, S_MULD: begin
                r_p0 <= w_nx * w_a0;
                r_p1 <= w_ny * w_a1;
                r_p2 <= w_nz * w_a2;
                if (r_state == S_MULD) r_dist <= w_sum - DW'(w_off);
            end
            S_SUM: r_slant <= -w_sum;
            S_CLS: begin
                r_is_exit  <= r_slant < -w_eps;
                r_is_entry <= r_slant > w_eps;
                r_miss     <= !(r_slant < -w_eps) && !(r_slant > w_eps) && (r_dist > w_slop);
                r_nmag     <= MW'(r_dist[DW-1] ? -r_dist : r_dist);
                r_dmag     <= MW'(r_slant[DW-1] ? -r_slant : r_slant);
                r_neg      <= r_dist[DW-1] != r_slant[DW-1];
            end
            S_OVF: begin
                if ({{(FB+1){1'b0}}, r_nmag} >= w_thr) begin
                    r_q <= r_neg ? 33'h080000000 : 33'h07FFFFFFF;
                end else begin
                    r_q   <= '0;
                    r_rem <= {r_nmag, {FB{1'b0}}};
                    r_bit <= rcpc_pkg::BIT_W'(rcpc_pkg::QUO_W - 1);
                end
            end
            // restoring division, one quotient bit a cycle
            S_DIV: begin
                if (w_ge) begin
                    r_rem        <= r_rem - rcpc_pkg::REM_W'(w_dsh);
                    r_q[r_bit]   <= 1'b1;
                end
                r_bit <= r_bit - rcpc_pkg::BIT_W'(1);
            end
            S_UPD: begin
                r_in_d  <= u_in_d;
                r_in_f  <= u_in_f;
                r_in_v  <= u_in_v;
                r_out_d <= u_out_d;
                r_out_f <= u_out_f;
                r_out_v <= u_out_v;
                r_miss  <= u_miss;
                r_k     <= r_k - AW'(1);
                if (u_hit) begin
                    r_res.hit        <= 1'b1;
                    r_res.entry_dist <= u_in_d;
                    r_res.exit_dist  <= u_out_d;
                    r_res.entry_face <= 6'(u_in_f);
                    r_res.exit_face  <= 6'(u_out_f);
                end else begin
                    r_res <= '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/ray_convex_polyhedron_clip_core.sv
// top level: ray clip against a convex solid of half-space planes
`timescale 1ns / 1ps
// Usage: items enter through a queue port (push/full) and leave through a
// queue port (empty/pop). A beat with func low loads one plane (unit normal
// and offset, Q16.16) into table entry plane_index and gives no result; a
// load beyond the table is dropped. A beat with func high shoots one ray and
// gives exactly one result beat: hit, entry and exit distance and face.
// The cfg channel (valid/ready, always ready) writes plane_count,
// parallel_slop and slant_epsilon; write it only while the block is idle.
// Flow: a load is written into the table as the back end takes it. A ray
// walks its planes one at a time through one table read port and three
// shared multipliers: each plane is read, multiplied with origin, then with
// direction, summed, classed and folded into the result; a plane that is
// not parallel first gets a clamp check and, when its quotient does not
// clamp, goes through the restoring divider, one quotient bit a cycle.
// A two-entry input queue lets up to two items wait while a ray is walked;
// a two-entry result queue decouples the output. When the receiver stalls
// the results fill the queue, the walk holds its last result, and full rises
// once the input queue is full. Reset empties both queues and sets
// plane_count to 4, parallel_slop to 1, slant_epsilon to 0; the plane table
// is not cleared and must be loaded before use.
module ray_convex_polyhedron_clip_core #(
    parameter int MAX_PLANES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  rcpc_pkg::t_in_item  i_in,
    output logic                empty,
    input  logic                pop,
    output rcpc_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    rcpc_pkg::t_cfg      r_cfg;
    rcpc_pkg::t_job      w_job;
    logic                w_avail;
    logic                w_take;
    logic                w_res_full;
    logic                w_res_push;
    rcpc_pkg::t_out_item w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plane_count   <= 7'd4;
            r_cfg.parallel_slop <= 16'd1;
            r_cfg.slant_epsilon <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rcpc_pkg::CFG_PLANE_COUNT:   r_cfg.plane_count   <= i_cfg_data[6:0];
                rcpc_pkg::CFG_PARALLEL_SLOP: r_cfg.parallel_slop <= i_cfg_data;
                rcpc_pkg::CFG_SLANT_EPSILON: r_cfg.slant_epsilon <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rcpc_front #(.MAX_PLANES(MAX_PLANES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_in),
        .i_take  (w_take),
        .o_avail (w_avail),
        .o_job   (w_job)
    );

    rcpc_back #(.MAX_PLANES(MAX_PLANES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (w_avail),
        .i_job      (w_job),
        .o_take     (w_take),
        .i_cfg      (r_cfg),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    rcpc_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_item  (w_res),
        .o_full  (w_res_full),
        .pop     (pop),
        .empty   (empty),
        .o_item  (o_out)
    );

    // the back end never offers a result into a full queue
    a_no_res_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full) else $error("result pushed into full queue");

    // the back end only takes a job that is waiting
    a_take_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> w_avail) else $error("job taken from empty input queue");

    // a result push is followed by a nonempty output queue
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |=> !empty) else $error("pushed result lost");

endmodule

### tb/sv/tb_top.sv
// testbench for the ray convex polyhedron clip core: queued stimulus, predictor and checker
`timescale 1ns / 1ps
module tb_top;

    localparam int NPLANES    = 64;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_GAP  = 60;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    rcpc_pkg::t_in_item  i_in;
    logic       empty;
    logic       pop;
    rcpc_pkg::t_out_item o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    ray_convex_polyhedron_clip_core #(.MAX_PLANES(NPLANES)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in(i_in),
        .empty(empty), .pop(pop), .o_out(o_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    // predictor state
    longint      pl_nx[NPLANES];
    longint      pl_ny[NPLANES];
    longint      pl_nz[NPLANES];
    longint      pl_off[NPLANES];
    logic [6:0]  cur_count = 7'd4;
    logic [15:0] cur_slop  = 16'd1;
    logic [15:0] cur_eps   = 16'd0;

    rcpc_pkg::t_in_item  pending_items[$];
    rcpc_pkg::t_out_item expected_hits[$];
    int        errors = 0;
    int        cfg_writes = 0;
    int        quiet_cycles = 0;
    bit        no_idle = 0;
    bit        hold_rx = 0;
    bit        hold_tx = 0;

    function automatic longint dot_q(longint ax, longint ay, longint az,
                                     longint bx, longint by, longint bz);
        return ((ax * bx) >>> rcpc_pkg::FRAC_BITS) + ((ay * by) >>> rcpc_pkg::FRAC_BITS)
             + ((az * bz) >>> rcpc_pkg::FRAC_BITS);
    endfunction

    // (num << FRAC_BITS) / den toward zero, clamped to 32 bits
    function automatic longint ratio_sat(longint num, longint den);
        bit          neg;
        logic [63:0] n, d, lim, q, r;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        q = n / d;
        r = n % d;
        if (q > (lim >> rcpc_pkg::FRAC_BITS))
            return neg ? -longint'(lim) : longint'(lim);
        for (int i = 0; i < rcpc_pkg::FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q[0] = 1'b1;
            end
        end
        if (q > lim)
            q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic rcpc_pkg::t_out_item clip_ray(rcpc_pkg::t_in_item it);
        rcpc_pkg::t_out_item res;
        longint    ox, oy, oz, dx, dy, dz, sdist, slant, s, eps, slop;
        longint    near_d, far_d;
        int        near_f, far_f, n;
        bit        near_v, far_v, miss;
        ox = it.origin_x; oy = it.origin_y; oz = it.origin_z;
        dx = it.dir_x;    dy = it.dir_y;    dz = it.dir_z;
        eps = cur_eps;
        slop = cur_slop;
        n = (cur_count > NPLANES) ? NPLANES : cur_count;
        near_d = 0; far_d = 0; near_f = 0; far_f = 0;
        near_v = 0; far_v = 0; miss = 0;
        for (int k = n - 1; k >= 0 && !miss; k--) begin
            sdist = dot_q(pl_nx[k], pl_ny[k], pl_nz[k], ox, oy, oz) - pl_off[k];
            slant = -dot_q(pl_nx[k], pl_ny[k], pl_nz[k], dx, dy, dz);
            if (slant < -eps) begin
                s = ratio_sat(sdist, slant);
                if (!far_v || s < far_d) begin
                    far_d = s; far_f = k; far_v = 1;
                end
            end else if (slant > eps) begin
                s = ratio_sat(sdist, slant);
                if (!near_v || s > near_d) begin
                    near_d = s; near_f = k; near_v = 1;
                end
            end else if (sdist > slop) begin
                miss = 1;
            end
            if (near_v && far_v && near_d > far_d)
                miss = 1;
        end
        res = '0;
        if (!miss && near_v && far_v && near_d < far_d) begin
            res.hit = 1'b1;
            res.entry_dist = near_d[31:0];
            res.exit_dist = far_d[31:0];
            res.entry_face = near_f[5:0];
            res.exit_face = far_f[5:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // monitor: beats on all three channels, checks results, watchdog
    always @(posedge i_clk) begin
        rcpc_pkg::t_out_item want;
        bit        moved;
        moved = 0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    rcpc_pkg::CFG_PLANE_COUNT:   cur_count = i_cfg_data[6:0];
                    rcpc_pkg::CFG_PARALLEL_SLOP: cur_slop = i_cfg_data;
                    rcpc_pkg::CFG_SLANT_EPSILON: cur_eps = i_cfg_data;
                    default: ;
                endcase
                cfg_writes++;
                moved = 1;
            end
            if (push && !full) begin
                if (i_in.func == rcpc_pkg::FUNC_LOAD) begin
                    pl_nx[i_in.plane_index] = i_in.normal_x;
                    pl_ny[i_in.plane_index] = i_in.normal_y;
                    pl_nz[i_in.plane_index] = i_in.normal_z;
                    pl_off[i_in.plane_index] = i_in.plane_offset;
                end else begin
                    expected_hits.push_back(clip_ray(i_in));
                end
                void'(pending_items.pop_front());
                moved = 1;
            end
            if (pop && !empty) begin
                moved = 1;
                if (expected_hits.size() == 0) begin
                    report_mismatch("unexpected result beat, hit", o_out.hit, 0);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_out.hit !== want.hit)
                        report_mismatch("hit", o_out.hit, want.hit);
                    if (o_out.entry_dist !== want.entry_dist)
                        report_mismatch("entry_dist", o_out.entry_dist, want.entry_dist);
                    if (o_out.exit_dist !== want.exit_dist)
                        report_mismatch("exit_dist", o_out.exit_dist, want.exit_dist);
                    if (o_out.entry_face !== want.entry_face)
                        report_mismatch("entry_face", o_out.entry_face, want.entry_face);
                    if (o_out.exit_face !== want.exit_face)
                        report_mismatch("exit_face", o_out.exit_face, want.exit_face);
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // driver: both queue ports change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            pop <= 1'b0;
        end else begin
            if (pending_items.size() > 0 && !hold_tx
                    && (no_idle || $urandom_range(99) >= 14)) begin
                push <= 1'b1;
                i_in <= pending_items[0];
            end else begin
                push <= 1'b0;
            end
            pop <= !hold_rx && (no_idle || $urandom_range(99) >= 14);
        end
    end

    function automatic rcpc_pkg::t_in_item plane_load(int idx, int nx, int ny, int nz,
                                                      int off);
        rcpc_pkg::t_in_item it;
        it = '0;
        it.func = rcpc_pkg::FUNC_LOAD;
        it.plane_index = idx[5:0];
        it.normal_x = nx; it.normal_y = ny; it.normal_z = nz;
        it.plane_offset = off;
        return it;
    endfunction

    function automatic rcpc_pkg::t_in_item ray_shot(int ox, int oy, int oz,
                                                    int dx, int dy, int dz);
        rcpc_pkg::t_in_item it;
        it = '0;
        it.func = rcpc_pkg::FUNC_RAY;
        it.origin_x = ox; it.origin_y = oy; it.origin_z = oz;
        it.dir_x = dx; it.dir_y = dy; it.dir_z = dz;
        return it;
    endfunction

    function automatic int span(int lim);
        return int'($urandom_range(2 * lim)) - lim;
    endfunction

    function automatic rcpc_pkg::t_in_item any_plane(int idx);
        return plane_load(idx, span(65536), span(65536), span(65536),
                          $urandom_range(1 << 20));
    endfunction

    // pad the unused fields with random bits so every bit of the beat moves
    function automatic rcpc_pkg::t_in_item noisy_item(bit is_ray);
        rcpc_pkg::t_in_item it;
        logic [383:0]       raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(rcpc_pkg::t_in_item)-1:0];
        it.func = is_ray ? rcpc_pkg::FUNC_RAY : rcpc_pkg::FUNC_LOAD;
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        int seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        wait (cfg_writes != seen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && expected_hits.size() == 0);
        repeat (DRAIN_GAP) @(posedge i_clk);
    endtask

    task automatic run_phase(int cnt, int slop, int eps, int nitems);
        int used, r;
        rcpc_pkg::t_in_item it;
        drain();
        write_reg(rcpc_pkg::CFG_PLANE_COUNT, cnt[15:0]);
        write_reg(rcpc_pkg::CFG_PARALLEL_SLOP, slop[15:0]);
        write_reg(rcpc_pkg::CFG_SLANT_EPSILON, eps[15:0]);
        used = (cnt > NPLANES) ? NPLANES : ((cnt == 0) ? NPLANES : cnt);
        for (int i = 0; i < nitems; i++) begin
            r = $urandom_range(99);
            if (r < 10)
                it = any_plane($urandom_range(used - 1));
            else if (r < 13)
                it = noisy_item(0);
            else if (r < 21)
                it = noisy_item(1);
            else if (r < 25)
                it = ray_shot(span(32768), span(32768), span(32768), 0, 0, 0);
            else
                it = ray_shot(span(32768), span(32768), span(32768),
                              span(131072), span(131072), span(131072));
            pending_items.push_back(it);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rcpc_pkg::CFG_PLANE_COUNT;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // unit box in x and y, reset settings
        pending_items.push_back(plane_load(0, 65536, 0, 0, 65536));
        pending_items.push_back(plane_load(1, -65536, 0, 0, 65536));
        pending_items.push_back(plane_load(2, 0, 65536, 0, 65536));
        pending_items.push_back(plane_load(3, 0, -65536, 0, 65536));
        pending_items.push_back(ray_shot(0, 0, 0, 65536, 0, 0));
        pending_items.push_back(ray_shot(0, 0, 0, -65536, 32768, 0));
        // outside and parallel beyond the slop
        pending_items.push_back(ray_shot(0, 5 << 16, 0, 65536, 0, 0));
        // just on the slop edge
        pending_items.push_back(ray_shot(0, 65537, 0, 65536, 0, 0));
        pending_items.push_back(ray_shot(0, 0, 0, 0, 0, 0));
        // entry beyond exit
        pending_items.push_back(ray_shot(-5 << 16, 0, 0, 65536, 65536, 0));
        // quotient clamps
        pending_items.push_back(ray_shot(0, 0, 0, 1, 0, 0));
        pending_items.push_back(ray_shot(0, 0, 0, -1, 1, 0));
        pending_items.push_back(ray_shot(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                         32'h80000000, 32'h80000000, 32'h80000000));
        pending_items.push_back(ray_shot(32'h80000000, 32'h80000000, 32'h80000000,
                                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_items.push_back(plane_load(3, 32'h80000000, 32'h7fffffff,
                                           32'h80000000, 32'h7fffffff));
        pending_items.push_back(ray_shot(65536, -65536, 0, 65536, 65536, 65536));
        pending_items.push_back(plane_load(3, 0, -65536, 0, 65536));
        pending_items.push_back(ray_shot(16384, -16384, 0, 65536, 65536, 0));

        // fill the whole table before wider counts
        drain();
        for (int i = 0; i < NPLANES; i++)
            pending_items.push_back(any_plane(i));

        run_phase(8, 0, 0, 150);
        run_phase(64, 65535, 65535, 20);
        run_phase(127, 1, 0, 15);
        run_phase(0, 65535, 0, 30);
        run_phase(1, 0, 65535, 60);

        // receiver stalls long while small rays keep coming
        drain();
        write_reg(rcpc_pkg::CFG_PLANE_COUNT, 16'd2);
        fork
            begin
                hold_rx = 1;
                repeat (800) @(posedge i_clk);
                hold_rx = 0;
            end
        join_none
        for (int i = 0; i < 40; i++)
            pending_items.push_back(ray_shot(span(32768), span(32768), 0,
                                             span(131072), span(131072), 0));

        // sender pauses until every result is back
        wait (pending_items.size() == 0);
        hold_tx = 1;
        wait (expected_hits.size() == 0);
        hold_tx = 0;

        no_idle = 1;
        run_phase(6, $urandom_range(65535), $urandom_range(65535), 200);
        drain();
        no_idle = 0;
        run_phase(16, $urandom_range(65535), 0, 150);
        run_phase(5, $urandom_range(65535), $urandom_range(4096), 200);
        run_phase(3, 0, 0, 100);

        drain();
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rcpc_pkg.sv
hw/rtl/rcpc_front.sv
hw/rtl/rcpc_resq.sv
hw/rtl/rcpc_back.sv
hw/rtl/ray_convex_polyhedron_clip_core.sv
tb/sv/tb_top.sv
